FILE: sv/bst_pkg.sv
// Shared types and constants for the bounded set table.
// Holds the request/result structs, operation and status codes, and table sizing.
// No dependencies.
package bst_pkg;

  // Table sizing
  localparam int CAPACITY = 8;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int KEY_W    = 32;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 4;

  localparam logic [COUNT_W-1:0] CAPACITY_C = COUNT_W'(CAPACITY);

  // Operation codes; the spare code behaves as a query
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [KEY_W-1:0] key;
  } in_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } out_res_t;

endpackage

FILE: sv/bounded_set_table_unit.sv
// Bounded set table: top level with sequencer, key store and result register.
// Depends on bst_pkg for types, codes and sizing.
//
// Usage:
//   Input channel (in_valid / in_stall / in_req) carries one request: an
//   insert, remove or membership query on a signed 32-bit key. Output
//   channel (out_valid / out_stall / out_res) returns one result per
//   request: a status code and the number of keys held afterwards.
//   Keys live packed in insertion order in a small single-port-read RAM.
//   A sequencer walks the table with one shared comparator, doing a RAM
//   read and then a compare for each entry. A remove that hits closes the
//   gap by reading each later entry and writing it one slot down.
//   in_stall is high while a request is in progress. The result register
//   holds a finished result while out_stall is high; a new request may be
//   taken meanwhile, and it waits at the end of its work until the
//   register frees up. Reset empties the set and drops any pending result.
module bounded_set_table_unit
  import bst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [COUNT_W-1:0]      idx_r, idx_nxt;
  logic [COUNT_W-1:0]      count_r, count_nxt;
  logic [KIND_W-1:0]       kind_r, kind_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [STATUS_W-1:0]     status_r, status_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_res_t                out_res_r, out_res_nxt;
  logic [COUNT_W-1:0]      idx_plus1;

  // Key store
  logic signed [KEY_W-1:0] mem [0:CAPACITY-1];
  logic signed [KEY_W-1:0] rd_data_r;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic [IDX_W-1:0]        mem_raddr;
  logic signed [KEY_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  assign idx_plus1 = idx_r + COUNT_W'(1);

  // Sequencer next-state logic
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    mem_we        = 1'b0;
    mem_waddr     = count_r[IDX_W-1:0];
    mem_wdata     = key_r;
    mem_raddr     = idx_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_req.kind;
          key_nxt   = in_req.key;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end

      // End of the held keys means a miss; otherwise fetch the next entry
      S_SCAN: begin
        if (idx_r == count_r) begin
          state_nxt = S_DONE;
          if (kind_r == KIND_INSERT) begin
            if (count_r < CAPACITY_C) begin
              mem_we     = 1'b1;
              count_nxt  = count_r + COUNT_W'(1);
              status_nxt = ST_ADDED;
            end else begin
              status_nxt = ST_FULL;
            end
          end else begin
            status_nxt = ST_NOTFOUND;
          end
        end else begin
          state_nxt = S_CMP;
        end
      end

      // Shared key comparator
      S_CMP: begin
        if (rd_data_r == key_r) begin
          unique case (kind_r)
            KIND_INSERT: begin
              status_nxt = ST_PRESENT;
              state_nxt  = S_DONE;
            end
            KIND_REMOVE: begin
              state_nxt = S_SHIFT_RD;
            end
            default: begin
              status_nxt = ST_FOUND;
              state_nxt  = S_DONE;
            end
          endcase
        end else begin
          idx_nxt   = idx_plus1;
          state_nxt = S_SCAN;
        end
      end

      // Close the gap: read the entry above, then write it one slot down
      S_SHIFT_RD: begin
        if (idx_plus1 < count_r) begin
          mem_raddr = idx_plus1[IDX_W-1:0];
          state_nxt = S_SHIFT_WR;
        end else begin
          count_nxt  = count_r - COUNT_W'(1);
          status_nxt = ST_REMOVED;
          state_nxt  = S_DONE;
        end
      end

      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[IDX_W-1:0];
        mem_wdata = rd_data_r;
        idx_nxt   = idx_plus1;
        state_nxt = S_SHIFT_RD;
      end

      // Hand the result over once the output register is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_res_nxt.status    = status_r;
          out_res_nxt.occupancy = OCC_W'(count_r);
          state_nxt             = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r     <= idx_nxt;
    kind_r    <= kind_nxt;
    key_r     <= key_nxt;
    status_r  <= status_nxt;
    out_res_r <= out_res_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: verif/bounded_set_table_unit_tb.sv
// Self-checking testbench for bounded_set_table_unit: insert, remove and query requests.
// A built-in set predictor checks every result; depends on bst_pkg and the unit under test.
`timescale 1ns / 100ps

module bounded_set_table_unit_tb;
  import bst_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int RANDOM_OPS   = 1430;
  localparam int POOL_SIZE    = 12;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 60;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    in_req_t req;
    bit      wait_drain;   // hold this request until all results are back
  } set_op_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_res;

  // Stimulus and scoreboard storage
  set_op_t  set_ops_queue[$];
  out_res_t predicted_results[$];
  logic [KEY_W-1:0] held_keys [CAPACITY];
  int       held_count = 0;
  int       mismatch_count = 0;
  int       idle_cycles = 0;
  bit       req_taken = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;
  int       stall_run = 0;

  bounded_set_table_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Set predictor: applies one request to the local copy of the table
  function automatic out_res_t apply_set_op(in_req_t r);
    out_res_t res;
    int slot;
    slot = -1;
    for (int i = 0; i < held_count; i++) begin
      if (slot < 0 && held_keys[i] == r.key) slot = i;
    end
    case (r.kind)
      KIND_INSERT: begin
        if (slot >= 0) begin
          res.status = ST_PRESENT;
        end else if (held_count < CAPACITY) begin
          held_keys[held_count] = r.key;
          held_count++;
          res.status = ST_ADDED;
        end else begin
          res.status = ST_FULL;
        end
      end
      KIND_REMOVE: begin
        if (slot >= 0) begin
          // close the gap so the table stays packed
          for (int j = slot; j + 1 < held_count; j++) held_keys[j] = held_keys[j + 1];
          held_count--;
          res.status = ST_REMOVED;
        end else begin
          res.status = ST_NOTFOUND;
        end
      end
      default: res.status = (slot >= 0) ? ST_FOUND : ST_NOTFOUND;
    endcase
    res.occupancy = OCC_W'(held_count);
    return res;
  endfunction

  task automatic push_op(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key, bit wait_drain);
    set_op_t op;
    op.req.kind   = kind;
    op.req.key    = key;
    op.wait_drain = wait_drain;
    set_ops_queue.push_back(op);
  endtask

  // Monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    out_res_t want;
    if (rst_n) begin
      idle_cycles++;
      if (in_valid && !in_stall) begin
        predicted_results.push_back(apply_set_op(in_req));
        req_taken = 1'b1;
        idle_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        if (predicted_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("Unexpected result: status %0d occupancy %0d",
                     out_res.status, out_res.occupancy);
        end else begin
          want = predicted_results.pop_front();
          if (out_res.status !== want.status || out_res.occupancy !== want.occupancy) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("Mismatch: status exp %0d got %0d, occupancy exp %0d got %0d",
                       want.status, out_res.status, want.occupancy, out_res.occupancy);
          end
        end
      end
    end
  end

  // Driver: bursts of requests with random gaps, changes on the falling edge
  always @(negedge clk) begin
    set_op_t op;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      // request still waiting, hold it
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (set_ops_queue.size() == 0) begin
      in_valid <= 1'b0;
    end else if (set_ops_queue[0].wait_drain && predicted_results.size() != 0) begin
      in_valid <= 1'b0;
    end else begin
      op = set_ops_queue.pop_front();
      in_req   <= op.req;
      in_valid <= 1'b1;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 24);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
    req_taken = 1'b0;
  end

  // Receiver stall pattern: short and long runs, with occasional quiet stretches
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      out_stall <= !out_stall;
      if (out_stall)
        stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(0, 15);
      else
        stall_run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(0, 8);
    end
  end

  // Watchdog on cycles without any accepted transfer
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(negedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus and end of test
  initial begin
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0] key;
    int insert_bias;
    int pick;

    // Directed: empty table, fill to capacity with extreme keys
    push_op(KIND_QUERY,  32'h0000_0000, 1'b0);
    push_op(KIND_REMOVE, 32'h0000_0000, 1'b0);
    push_op(KIND_INSERT, 32'h8000_0000, 1'b0);
    push_op(KIND_INSERT, 32'h7fff_ffff, 1'b0);
    push_op(KIND_INSERT, 32'h0000_0000, 1'b0);
    push_op(KIND_INSERT, 32'hffff_ffff, 1'b0);
    push_op(KIND_INSERT, 32'h0000_0001, 1'b0);
    push_op(KIND_INSERT, 32'h5555_5555, 1'b0);
    push_op(KIND_INSERT, 32'haaaa_aaaa, 1'b0);
    push_op(KIND_INSERT, 32'h0000_0007, 1'b0);
    // duplicate while full, then a new key while full
    push_op(KIND_INSERT, 32'hffff_ffff, 1'b0);
    push_op(KIND_INSERT, 32'h1234_5678, 1'b0);
    // spare kind acts as a query
    push_op(KIND_SPARE,  32'h7fff_ffff, 1'b0);
    push_op(KIND_SPARE,  32'h1234_5678, 1'b0);
    push_op(KIND_QUERY,  32'h8000_0000, 1'b0);
    // removes at the middle, head and tail, and of an absent key
    push_op(KIND_REMOVE, 32'h0000_0000, 1'b0);
    push_op(KIND_REMOVE, 32'h8000_0000, 1'b0);
    push_op(KIND_REMOVE, 32'h0000_0007, 1'b0);
    push_op(KIND_REMOVE, 32'h1234_5678, 1'b0);
    push_op(KIND_QUERY,  32'h0000_0000, 1'b0);
    push_op(KIND_QUERY,  32'haaaa_aaaa, 1'b0);
    push_op(KIND_INSERT, 32'h8000_0000, 1'b0);
    push_op(KIND_QUERY,  32'h8000_0000, 1'b0);

    // Random: phases with a shifting insert bias over a small key pool
    insert_bias = 50;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 60 == 0) begin
        insert_bias = $urandom_range(15, 75);
        foreach (key_pool[i]) key_pool[i] = $urandom;
        if ($urandom_range(0, 1) == 1) begin
          key_pool[0] = 32'h8000_0000;
          key_pool[1] = 32'h7fff_ffff;
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < insert_bias) begin
        kind = KIND_INSERT;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) kind = KIND_REMOVE;
        else if (pick < 93) kind = KIND_QUERY;
        else kind = KIND_SPARE;
      end
      key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                       : $urandom;
      // first random request always waits for a drained pipeline
      push_op(kind, key, n == 0 || $urandom_range(0, 199) == 0);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (set_ops_queue.size() == 0 && !in_valid);
    wait (predicted_results.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && predicted_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
sv/bst_pkg.sv
sv/bounded_set_table_unit.sv
verif/bounded_set_table_unit_tb.sv
